### design/uae_pkg.sv
package uae_pkg;

  // Depth of the command queue between the parser and the emitter.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Largest number of raw bytes a single input byte can release.
  localparam int unsigned RAW_MAX = 4;

  // Number of decimal digit positions needed for code points up to U+10FFFF.
  localparam int unsigned DEC_DIGITS = 7;

  localparam logic [20:0] BMP_MAX = 21'h00FFFF;

  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef logic [23:0] dec_step_t;

  localparam dec_step_t POW10 [DEC_DIGITS] = '{
    24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000
  };

  // One unit of work for the emitter: either a run of raw bytes or one
  // numeric entity, with the end-of-string mark for its final byte.
  typedef struct packed {
    logic [RAW_MAX-1:0][7:0] raw;
    logic [2:0]              raw_cnt;
    logic                    ent;
    logic [20:0]             cp;
    logic                    last;
  } cmd_t;

endpackage

### design/uae_in_if.sv
interface uae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

### design/uae_out_if.sv
interface uae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### design/uae_front.sv
module uae_front (
  input  logic          clk,
  input  logic          rst,
  uae_in_if.sink        utf8,
  input  logic          q_full,
  output logic          push,
  output uae_pkg::cmd_t cmd
);
  import uae_pkg::*;

  logic [7:0] pb [3];
  logic [1:0] pcnt;
  logic [2:0] elen;

  logic       accept;
  logic [7:0] b;
  logic       open_seq;
  logic       sec_ok;
  logic       ok;
  logic       complete;
  logic       big;
  logic [2:0] lead_len;
  logic       incl_pend;
  logic       incl_b;
  logic [7:0] lo;
  logic [7:0] hi;
  logic [20:0] cp;
  logic [1:0] pcnt_next;
  logic [2:0] elen_next;

  assign utf8.ready = !q_full;
  assign accept     = utf8.valid && !q_full;
  assign b          = utf8.in_byte;
  assign open_seq   = (elen != 3'd0) && (pcnt != 2'd0);

  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    unique case (pb[0])
      8'hE0:   lo = 8'hA0;
      8'hED:   hi = 8'h9F;
      8'hF0:   lo = 8'h90;
      8'hF4:   hi = 8'h8F;
      default: ;
    endcase
  end

  assign sec_ok   = (b >= lo) && (b <= hi);
  assign ok       = open_seq && ((pcnt == 2'd1) ? sec_ok : (b[7:6] == 2'b10));
  assign complete = ok && (({1'b0, pcnt} + 3'd1) == elen);

  always_comb begin
    unique case (elen)
      3'd2:    cp = {10'd0, pb[0][4:0], b[5:0]};
      3'd3:    cp = {5'd0, pb[0][3:0], pb[1][5:0], b[5:0]};
      default: cp = {pb[0][2:0], pb[1][5:0], pb[2][5:0], b[5:0]};
    endcase
  end

  assign big = cp > BMP_MAX;

  always_comb begin
    if (b >= 8'hC2 && b <= 8'hDF) begin
      lead_len = 3'd2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      lead_len = 3'd3;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  // The raw output of one step is always a prefix of the held bytes,
  // optionally followed by the new byte.
  assign incl_pend = open_seq &&
                     (!ok || (complete && !big) || (!complete && utf8.in_last));
  assign incl_b    = (complete && !big) ||
                     (!ok && ((lead_len == 3'd0) || utf8.in_last)) ||
                     (ok && !complete && utf8.in_last);

  always_comb begin
    for (int i = 0; i < RAW_MAX; i++) begin
      if (incl_pend && (i < 3) && (2'(i) < pcnt)) begin
        cmd.raw[i] = pb[i];
      end else begin
        cmd.raw[i] = b;
      end
    end
    cmd.raw_cnt = (incl_pend ? {1'b0, pcnt} : 3'd0) + {2'b00, incl_b};
    cmd.ent     = complete && big;
    cmd.cp      = cp;
    cmd.last    = utf8.in_last;
  end

  assign push = accept && (cmd.ent || (cmd.raw_cnt != 3'd0));

  always_comb begin
    pcnt_next = 2'd0;
    elen_next = 3'd0;
    if (ok && !complete && !utf8.in_last) begin
      pcnt_next = pcnt + 2'd1;
      elen_next = elen;
    end else if (!ok && (lead_len != 3'd0) && !utf8.in_last) begin
      pcnt_next = 2'd1;
      elen_next = lead_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt <= 2'd0;
      elen <= 3'd0;
    end else if (accept) begin
      pcnt <= pcnt_next;
      elen <= elen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (ok && !complete) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) == pcnt) begin
            pb[i] <= b;
          end
        end
      end else if (!ok && (lead_len != 3'd0)) begin
        pb[0] <= b;
      end
    end
  end

endmodule

### design/uae_queue.sv
module uae_queue #(
  parameter int unsigned DEPTH = uae_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uae_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output uae_pkg::cmd_t head
);
  import uae_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

### design/uae_back.sv
module uae_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  uae_pkg::cmd_t head,
  output logic          pop,
  uae_out_if.source     encoded
);
  import uae_pkg::*;

  localparam logic [2:0] PH_HEAD = 3'd0;
  localparam logic [2:0] PH_RAW  = 3'd1;
  localparam logic [2:0] PH_HASH = 3'd2;
  localparam logic [2:0] PH_DIG  = 3'd3;
  localparam logic [2:0] PH_SEMI = 3'd4;

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic [1:0]  pos;
  logic [1:0]  pos_next;
  logic [2:0]  k;
  logic [2:0]  k_next;
  logic [20:0] rem;
  logic [20:0] rem_next;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;

  logic        fire;
  logic        final_byte;
  logic [7:0]  byte_next;
  logic [3:0]  digit;
  dec_step_t   sub;
  logic [2:0]  start_k;

  assign encoded.valid    = out_valid;
  assign encoded.out_byte = out_byte;
  assign encoded.out_last = out_last;

  assign fire = head_valid && (!out_valid || encoded.ready);
  assign pop  = fire && final_byte;

  // Leading digit position: code points here are at least 65536.
  always_comb begin
    if (head.cp >= 21'd1000000) begin
      start_k = 3'd6;
    end else if (head.cp >= 21'd100000) begin
      start_k = 3'd5;
    end else begin
      start_k = 3'd4;
    end
  end

  // One decimal digit per step, most significant first.
  always_comb begin
    digit = 4'd0;
    sub   = '0;
    for (int m = 1; m <= 9; m++) begin
      if ({3'b000, rem} >= POW10[k] * 24'(m)) begin
        digit = 4'(m);
        sub   = POW10[k] * 24'(m);
      end
    end
  end

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    k_next     = k;
    rem_next   = rem;
    final_byte = 1'b0;
    byte_next  = head.raw[0];
    unique case (phase)
      PH_HEAD: begin
        if (head.ent) begin
          byte_next  = CHAR_AMP;
          phase_next = PH_HASH;
          rem_next   = head.cp;
          k_next     = start_k;
        end else if (head.raw_cnt == 3'd1) begin
          final_byte = 1'b1;
        end else begin
          phase_next = PH_RAW;
          pos_next   = 2'd1;
        end
      end
      PH_RAW: begin
        byte_next = head.raw[pos];
        if ({1'b0, pos} == head.raw_cnt - 3'd1) begin
          final_byte = 1'b1;
        end else begin
          pos_next = pos + 2'd1;
        end
      end
      PH_HASH: begin
        byte_next  = CHAR_HASH;
        phase_next = PH_DIG;
      end
      PH_DIG: begin
        byte_next = CHAR_ZERO + {4'b0000, digit};
        rem_next  = rem - sub[20:0];
        if (k == 3'd0) begin
          phase_next = PH_SEMI;
        end else begin
          k_next = k - 3'd1;
        end
      end
      PH_SEMI: begin
        byte_next  = CHAR_SEMI;
        final_byte = 1'b1;
      end
      default: begin
        phase_next = PH_HEAD;
      end
    endcase
    if (final_byte) begin
      phase_next = PH_HEAD;
      pos_next   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEAD;
      pos       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        phase     <= phase_next;
        pos       <= pos_next;
        out_valid <= 1'b1;
      end else if (encoded.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      k        <= k_next;
      rem      <= rem_next;
      out_byte <= byte_next;
      out_last <= final_byte && head.last;
    end
  end

endmodule

### design/utf8_astral_entity_encoder_unit.sv
// Channel   Direction  Payload            Meaning
// utf8      sink       in_byte, in_last   UTF-8 string, one byte per transfer
// encoded   source     out_byte, out_last encoded string, one byte per transfer
//
// An input transfer can be taken in every cycle while the command queue has
// room; the parser classifies each byte in the cycle it arrives.
// The emitter sends one output byte per cycle from its output register
// while the output is ready; a character above U+FFFF becomes eight to ten
// bytes ('&', '#', five to seven digits, ';'), other bytes one each. Each
// released command is registered in the queue, its first byte then in the
// output register. Reset is synchronous and empties the queue and output.
// A stall on the output fills the queue, after which input ready falls.
module utf8_astral_entity_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = uae_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  uae_in_if.sink    utf8,
  uae_out_if.source encoded
);
  import uae_pkg::*;

  // Commands travel from the parser to the emitter through a short queue,
  // so that a long entity on the output does not stop the parser at once.
  logic q_full;
  logic push;
  cmd_t cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  uae_front u_front (
    .clk    (clk),
    .rst    (rst),
    .utf8   (utf8),
    .q_full (q_full),
    .push   (push),
    .cmd    (cmd)
  );

  uae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // The emitter walks through the head command one byte per transfer and
  // releases it from the queue with its final byte.
  uae_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .encoded    (encoded)
  );

endmodule

### design/uae_checker.sv
module uae_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Reset empties the output register.
  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // The queue only fills while the emitter holds a byte on the output.
  a_full_implies_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with nothing on the output");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped during a stall");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output payload changed during a stall");

endmodule

bind utf8_astral_entity_encoder_unit uae_checker u_uae_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (utf8.ready),
  .out_valid (encoded.valid),
  .out_ready (encoded.ready),
  .out_byte  (encoded.out_byte),
  .out_last  (encoded.out_last)
);
